### hdl/wch_pkg.sv
// Shared types and constants of the chained 128-to-64 word hash.
`timescale 1ns / 1ps
`default_nettype none

package wch_pkg;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int WORD_BYTES  = WORD_W / 8;
    localparam int COUNT_W     = 4;

    localparam logic [WORD_W-1:0] MIX_MULT  = 64'h9ddfea08eb382d69;
    localparam int                MIX_SHIFT = 47;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [WORD_W-1:0] word;   // masked message word
        logic              mix;    // word carries at least one byte
        logic              last;   // final word of the message
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } t_back_state;

    // Partial products of one 64x64 (low half) multiplication.
    typedef enum logic [1:0] {
        STEP_LL,
        STEP_HL,
        STEP_LH,
        STEP_SUM
    } t_mul_step;

    typedef enum logic [1:0] {
        RND_FIRST,
        RND_SECOND,
        RND_FINAL
    } t_mix_round;

endpackage

`default_nettype wire

### hdl/wch_front.sv
// Front stage: accepts words, masks unused bytes and classifies them.
`timescale 1ns / 1ps
`default_nettype none

module wch_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire logic [wch_pkg::WORD_W-1:0]       i_data_word,
    input  wire logic [wch_pkg::COUNT_W-1:0]      i_byte_count,
    input  wire logic                             i_last_word,
    output logic                                  o_full,
    input  wire wch_pkg::t_q_status               i_q_status,
    output logic                                  o_q_push,
    output wch_pkg::t_item                        o_q_item
);

    logic           r_valid;
    logic           n_valid;
    wch_pkg::t_item r_item;
    wch_pkg::t_item w_item;
    logic           w_accept;
    logic           w_drain;

    // Keep only the low bytes below the count; counts above eight keep all.
    always_comb begin
        w_item.word = '0;
        for (int i = 0; i < wch_pkg::WORD_BYTES; i++) begin
            if (i_byte_count > wch_pkg::COUNT_W'(i)) begin
                w_item.word[8*i +: 8] = i_data_word[8*i +: 8];
            end
        end
        w_item.mix  = (i_byte_count != '0);
        w_item.last = i_last_word;
    end

    assign w_drain  = r_valid && !i_q_status.full;
    assign o_full   = r_valid && i_q_status.full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_valid;
    assign o_q_item = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_item;
        end
    end

endmodule

`default_nettype wire

### hdl/wch_queue.sv
// Short first-in first-out queue between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module wch_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire wch_pkg::t_item      i_wr_item,
    input  wire logic                i_pop,
    output wch_pkg::t_item           o_rd_item,
    output wch_pkg::t_q_status       o_status
);

    wch_pkg::t_item                     r_mem [wch_pkg::QUEUE_DEPTH];
    logic [wch_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [wch_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [wch_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic [wch_pkg::QUEUE_CNT_W-1:0]    n_count;
    logic                               w_wr_en;
    logic                               w_rd_en;

    assign o_status.full  = (r_count == wch_pkg::QUEUE_CNT_W'(wch_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_wr_en        = i_push && !o_status.full;
    assign w_rd_en        = i_pop && !o_status.empty;
    assign o_rd_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (w_rd_en && !w_wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wch_pkg::QUEUE_CNT_W'(wch_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wch_pkg::QUEUE_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[wch_pkg::QUEUE_PTR_W-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

### hdl/wch_back.sv
// Back stage: folds queued words into the running hash with one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module wch_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire wch_pkg::t_q_status           i_q_status,
    input  wire wch_pkg::t_item               i_q_item,
    output logic                              o_q_pop,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [wch_pkg::WORD_W-1:0]        o_hash_value
);

    wch_pkg::t_back_state              r_state, n_state;
    wch_pkg::t_mul_step                r_step, n_step;
    wch_pkg::t_mix_round               r_round, n_round;
    logic [wch_pkg::WORD_W-1:0]        r_hash, n_hash;
    logic [wch_pkg::WORD_W-1:0]        r_opnd, n_opnd;
    logic [wch_pkg::WORD_W-1:0]        r_plo, n_plo;
    logic [wch_pkg::HALF_W-1:0]        r_cross, n_cross;
    logic                              r_last, n_last;
    logic [wch_pkg::WORD_W-1:0]        r_res, n_res;
    logic                              r_res_valid, n_res_valid;

    logic [wch_pkg::HALF_W-1:0]        w_mul_a;
    logic [wch_pkg::HALF_W-1:0]        w_mul_b;
    logic [wch_pkg::WORD_W-1:0]        w_prod;
    logic [wch_pkg::WORD_W-1:0]        w_m;
    logic [wch_pkg::WORD_W-1:0]        w_xs;
    logic                              w_res_free;
    logic                              w_res_load;

    // Shared 32x32 multiplier; the constant half is picked by step.
    always_comb begin
        unique case (r_step)
            wch_pkg::STEP_HL: begin
                w_mul_a = r_opnd[wch_pkg::WORD_W-1:wch_pkg::HALF_W];
                w_mul_b = wch_pkg::MIX_MULT[wch_pkg::HALF_W-1:0];
            end
            wch_pkg::STEP_LH: begin
                w_mul_a = r_opnd[wch_pkg::HALF_W-1:0];
                w_mul_b = wch_pkg::MIX_MULT[wch_pkg::WORD_W-1:wch_pkg::HALF_W];
            end
            default: begin
                w_mul_a = r_opnd[wch_pkg::HALF_W-1:0];
                w_mul_b = wch_pkg::MIX_MULT[wch_pkg::HALF_W-1:0];
            end
        endcase
    end

    assign w_prod = wch_pkg::WORD_W'(w_mul_a) * wch_pkg::WORD_W'(w_mul_b);

    // Low 64 bits of the full product; cross terms only touch the upper half.
    assign w_m  = {r_plo[wch_pkg::WORD_W-1:wch_pkg::HALF_W] + r_cross,
                   r_plo[wch_pkg::HALF_W-1:0]};
    assign w_xs = w_m ^ (w_m >> wch_pkg::MIX_SHIFT);

    assign w_res_free = !r_res_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_round     = r_round;
        n_hash      = r_hash;
        n_opnd      = r_opnd;
        n_plo       = r_plo;
        n_cross     = r_cross;
        n_last      = r_last;
        n_res       = r_res;
        w_res_load  = 1'b0;
        o_q_pop     = 1'b0;

        unique case (r_state)
            wch_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.mix) begin
                        n_opnd  = i_q_item.word ^ r_hash;
                        n_last  = i_q_item.last;
                        n_step  = wch_pkg::STEP_LL;
                        n_round = wch_pkg::RND_FIRST;
                        n_state = wch_pkg::ST_MUL;
                    end else if (i_q_item.last) begin
                        n_state = wch_pkg::ST_EMIT;
                    end
                end
            end
            wch_pkg::ST_MUL: begin
                unique case (r_step)
                    wch_pkg::STEP_LL: begin
                        n_plo  = w_prod;
                        n_step = wch_pkg::STEP_HL;
                    end
                    wch_pkg::STEP_HL: begin
                        n_cross = w_prod[wch_pkg::HALF_W-1:0];
                        n_step  = wch_pkg::STEP_LH;
                    end
                    wch_pkg::STEP_LH: begin
                        n_cross = r_cross + w_prod[wch_pkg::HALF_W-1:0];
                        n_step  = wch_pkg::STEP_SUM;
                    end
                    wch_pkg::STEP_SUM: begin
                        n_step = wch_pkg::STEP_LL;
                        unique case (r_round)
                            wch_pkg::RND_FIRST: begin
                                n_opnd  = r_hash ^ w_xs;
                                n_round = wch_pkg::RND_SECOND;
                            end
                            wch_pkg::RND_SECOND: begin
                                n_opnd  = w_xs;
                                n_round = wch_pkg::RND_FINAL;
                            end
                            default: begin
                                n_hash  = w_m;
                                n_state = r_last ? wch_pkg::ST_EMIT : wch_pkg::ST_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        n_step = wch_pkg::STEP_LL;
                    end
                endcase
            end
            wch_pkg::ST_EMIT: begin
                if (w_res_free) begin
                    w_res_load = 1'b1;
                    n_res      = r_hash;
                    n_hash     = '0;
                    n_state    = wch_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wch_pkg::ST_IDLE;
            end
        endcase

        n_res_valid = w_res_load || (r_res_valid && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wch_pkg::ST_IDLE;
            r_step      <= wch_pkg::STEP_LL;
            r_round     <= wch_pkg::RND_FIRST;
            r_hash      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_round     <= n_round;
            r_hash      <= n_hash;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd  <= n_opnd;
        r_plo   <= n_plo;
        r_cross <= n_cross;
        r_last  <= n_last;
        r_res   <= n_res;
    end

    assign o_empty      = !r_res_valid;
    assign o_hash_value = r_res;

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(r_state == wch_pkg::ST_EMIT))
        else $error("result appeared outside the emit state");

    a_round_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wch_pkg::ST_MUL && r_step != wch_pkg::STEP_SUM) |=> $stable(r_round))
        else $error("mix round advanced before the product was complete");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_pop) |=> (r_res_valid && $stable(r_res)))
        else $error("waiting result changed or vanished");

endmodule

`default_nettype wire

### hdl/word_chain_hash_128_to_64_top.sv
// Top level of the chained 128-to-64 word hash: front stage, queue and back stage.
`timescale 1ns / 1ps
`default_nettype none

// The block hashes a message given as a stream of 64-bit little-endian words,
// one transaction per word, through queue-style ports: push a word while full
// is low, and pop the 64-bit hash while empty is low. Bytes above the byte
// count are zeroed; a word with count zero is not combined, so an empty message
// hashes to zero. Every other word is folded into the running hash by the
// 128-to-64 mix (three multiplications by 0x9ddfea08eb382d69 with xor-shifts by
// 47). The word that has the last flag produces one result and clears the
// running hash. In the back stage a combined word is popped from the queue and
// then goes through three multiplications, and a last word, combined or skipped,
// then hands the hash to the output register; a skipped word is not multiplied.
// The back stage takes no new word until it is through with the current one, as
// it has only the single 32x32 multiplier, which builds each 64-bit product from
// three partial products and a final sum. A front register and a four-entry
// queue let the block take several words while the back stage is busy, and the
// output register holds a finished hash while the next message is being worked on.
module word_chain_hash_128_to_64_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [wch_pkg::WORD_W-1:0]    i_data_word,
    input  wire logic [wch_pkg::COUNT_W-1:0]   i_byte_count,
    input  wire logic                          i_last_word,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [wch_pkg::WORD_W-1:0]         o_hash_value
);

    wch_pkg::t_q_status w_q_status;
    wch_pkg::t_item     w_wr_item;
    wch_pkg::t_item     w_rd_item;
    logic               w_q_push;
    logic               w_q_pop;

    // Mask and classify each accepted word, then hand it to the queue.
    wch_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .o_full       (o_full),
        .i_q_status   (w_q_status),
        .o_q_push     (w_q_push),
        .o_q_item     (w_wr_item)
    );

    // Decouple the front from the multi-cycle mixing.
    wch_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_q_push),
        .i_wr_item (w_wr_item),
        .i_pop     (w_q_pop),
        .o_rd_item (w_rd_item),
        .o_status  (w_q_status)
    );

    // Fold words into the running hash and present finished hashes.
    wch_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_q_item     (w_rd_item),
        .o_q_pop      (w_q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_hash_value (o_hash_value)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the chained 128-to-64 word hash.
`timescale 1ns / 1ps

module tb_top;

    localparam int WORD_W  = wch_pkg::WORD_W;
    localparam int COUNT_W = wch_pkg::COUNT_W;

    localparam logic [WORD_W-1:0] HASH_MUL      = 64'h9ddfea08eb382d69;
    localparam int                HASH_SHIFT    = 47;
    localparam int                BYTES_PER_WORD = 8;
    localparam int                CYCLE_LIMIT   = 1_000_000;
    localparam int                SETTLE_CYCLES = 64;
    localparam int                MAX_REPORTS   = 10;

    // Receiver behavior: pop every cycle, on a coin toss, or only now and then.
    typedef enum int {
        POP_EVERY,
        POP_HALF,
        POP_SPARSE
    } t_pop_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_push;
    logic                o_full;
    logic [WORD_W-1:0]   i_data_word;
    logic [COUNT_W-1:0]  i_byte_count;
    logic                i_last_word;
    logic                o_empty;
    logic                i_pop;
    logic [WORD_W-1:0]   o_hash_value;

    word_chain_hash_128_to_64_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_hash_value (o_hash_value)
    );

    // Predicted chain value and the hashes still owed by the block, oldest first.
    logic [WORD_W-1:0] chain_state;
    logic [WORD_W-1:0] pending_hashes[$];

    int fail_count;
    int reported;
    int words_sent;
    int burst_left;
    int holdoff_request;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop for a hung block or a lost result.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[word_chain_hash_128_to_64_top] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Zero every byte above the valid count; counts of eight and up keep the word.
    function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] w,
                                                     input int n_bytes);
        if (n_bytes >= BYTES_PER_WORD)
            return w;
        return w & ((64'd1 << (8 * n_bytes)) - 64'd1);
    endfunction

    // The full 128-to-64 mix: fold a masked word into the chain value.
    function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] acc,
                                                    input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = (w ^ acc) * HASH_MUL;
        a = a ^ (a >> HASH_SHIFT);
        b = (acc ^ a) * HASH_MUL;
        b = b ^ (b >> HASH_SHIFT);
        b = b * HASH_MUL;
        return b;
    endfunction

    // Advance the predicted chain for one accepted word; queue a hash on the last one.
    task automatic predict_word(input logic [WORD_W-1:0] data,
                                input logic [COUNT_W-1:0] count,
                                input logic last);
        int n_bytes;
        n_bytes = (count > BYTES_PER_WORD) ? BYTES_PER_WORD : int'(count);
        if (n_bytes != 0)
            chain_state = fold_word(chain_state, keep_bytes(data, n_bytes));
        if (last) begin
            pending_hashes = {pending_hashes, chain_state};
            chain_state = '0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Result checking: compare each popped hash with the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : hash_checker
        logic [WORD_W-1:0] want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_hashes.size() == 0) begin
                fail_count++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected hash %h, none pending", o_hash_value);
                end
            end else begin
                want = pending_hashes.pop_front();
                if (o_hash_value !== want) begin
                    fail_count++;
                    if (reported < MAX_REPORTS) begin
                        reported++;
                        $display("hash mismatch: expected %h, got %h", want, o_hash_value);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: switch between pop patterns of random length; honor a
    // requested hold-off by keeping pop low for that many cycles.
    // ---------------------------------------------------------------------
    initial begin : receiver
        t_pop_mode mode;
        int        mode_left;
        int        hold_left;
        i_pop     = 1'b0;
        mode      = POP_EVERY;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request > 0) begin
                hold_left       = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    mode = POP_EVERY;
                        2, 3:    mode = POP_HALF;
                        default: mode = POP_SPARSE;
                    endcase
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    POP_EVERY:  i_pop <= 1'b1;
                    POP_HALF:   i_pop <= 1'($urandom_range(0, 1));
                    POP_SPARSE: i_pop <= ($urandom_range(0, 7) == 0);
                    default:    i_pop <= 1'b1;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------------

    // Mostly random words, with all-zero and all-one words mixed in.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word until accepted. Call at a falling edge; returns at a falling
    // edge with push still high, so the caller must send again or idle right away.
    task automatic send_word(input logic [WORD_W-1:0] data,
                             input logic [COUNT_W-1:0] count,
                             input logic last);
        int gap;
        // Work in bursts; drop push for a random gap between them.
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_push       <= 1'b1;
        i_data_word  <= data;
        i_byte_count <= count;
        i_last_word  <= last;
        // Hold the transaction until an edge sees full low.
        do @(posedge i_clk); while (o_full);
        predict_word(data, count, last);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering words and wait for every predicted hash to be popped.
    task automatic wait_for_drain();
        i_push <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // A last word with no bytes is never combined: the hash is the reset value.
    task automatic test_empty_message();
        send_word(rand_word(), 4'd0, 1'b1);
        send_word('1, 4'd0, 1'b1);
    endtask

    // Single-word messages with every byte count from one to eight, to exercise the byte masking.
    task automatic test_byte_masking();
        send_word('1, 4'd8, 1'b1);
        send_word('0, 4'd8, 1'b1);
        for (int c = 1; c < BYTES_PER_WORD; c++)
            send_word('1, COUNT_W'(c), 1'b1);
    endtask

    // Counts above eight saturate: all three must hash alike.
    task automatic test_count_saturation();
        send_word(64'h0123456789abcdef, 4'd9, 1'b1);
        send_word(64'h0123456789abcdef, 4'd15, 1'b1);
        send_word(64'h0123456789abcdef, 4'd8, 1'b1);
    endtask

    // A short word ahead of the last one is masked and combined anyway.
    task automatic test_short_word_mid_message();
        send_word(rand_word(), 4'd3, 1'b0);
        send_word(rand_word(), 4'd8, 1'b1);
    endtask

    // Words with no bytes inside a message and as its last word are skipped.
    task automatic test_skipped_words();
        send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), 4'd0, 1'b0);
        send_word(rand_word(), 4'd8, 1'b1);
        send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), 4'd0, 1'b1);
    endtask

    // Hold the receiver off long enough for results to pile up and the input to
    // stall on full, while the sender keeps offering one-word messages.
    task automatic test_output_backpressure();
        holdoff_request = 400;
        repeat (32) send_word(rand_word(), 4'd8, 1'b1);
        wait_for_drain();
    endtask

    // Random messages: mostly well-formed (full words, last word with 1 to 8
    // bytes), the rest with skipped words, random counts, stray last flags,
    // or an empty last word.
    task automatic test_random_messages(input int n_words);
        int                 stop_at;
        int                 n_len;
        int                 kind;
        logic [COUNT_W-1:0] cnt;
        logic               lst;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            kind  = $urandom_range(0, 9);
            n_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                : $urandom_range(1, 6);
            for (int k = 0; k < n_len; k++) begin
                lst = (k == n_len - 1);
                case (kind)
                    7: begin
                        cnt = COUNT_W'($urandom_range(0, 15));
                        lst = lst | ($urandom_range(0, 7) == 0);
                    end
                    8: begin
                        if ($urandom_range(0, 3) == 0)
                            cnt = '0;
                        else
                            cnt = lst ? COUNT_W'($urandom_range(0, 8)) : 4'd8;
                    end
                    9: cnt = lst ? 4'd0 : 4'd8;
                    default: cnt = lst ? COUNT_W'($urandom_range(1, 8)) : 4'd8;
                endcase
                send_word(rand_word(), cnt, lst);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_push          = 1'b0;
        i_data_word     = '0;
        i_byte_count    = '0;
        i_last_word     = 1'b0;
        chain_state     = '0;
        fail_count      = 0;
        reported        = 0;
        words_sent      = 0;
        burst_left      = 0;
        holdoff_request = 0;

        // Hold reset, then release it away from the rising edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_byte_masking();
        test_count_saturation();
        test_short_word_mid_message();
        test_skipped_words();
        wait_for_drain();

        test_output_backpressure();

        test_random_messages(800);
        wait_for_drain();
        test_random_messages(750);

        // Drain, then let any stray result surface before the verdict.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_hashes.size() == 0)
            $display("[word_chain_hash_128_to_64_top] OK");
        else
            $display("[word_chain_hash_128_to_64_top] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/wch_pkg.sv
hdl/wch_front.sv
hdl/wch_queue.sv
hdl/wch_back.sv
hdl/word_chain_hash_128_to_64_top.sv
bench/tb_top.sv
